@@ hdl/qfrm_pkg.sv @@
// Shared constants for the rotation matrix to quaternion converter.
// No dependencies.
package qfrm_pkg;

    // which quaternion component comes from the square root
    typedef logic [1:0] t_diag;

    localparam t_diag DIAG_X = 2'd0;
    localparam t_diag DIAG_Y = 2'd1;
    localparam t_diag DIAG_Z = 2'd2;
    localparam t_diag DIAG_W = 2'd3;

    localparam int NUM_LANES = 3;

endpackage

@@ hdl/quaternion_from_rotation_matrix.sv @@
// Rotation matrix to unit quaternion converter, fully pipelined.
// Depends on qfrm_pkg.
//
// Takes one 3x3 rotation matrix per cycle while the output is not stalled
// and returns one quaternion per transfer, in input order. The pipe has HW
// square-root stages (one result bit each) and NW divider stages (one
// quotient bit each), between input, divider-input and output registers.
// The three off-diagonal components share the square root and run in three
// parallel divider lanes. When the square-root argument is not positive,
// all components are zero and tuser bit 0 is set. The whole pipe holds
// while the output transfer is stalled.
module quaternion_from_rotation_matrix
    import qfrm_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // r11, r12, r13, r21, r22, r23, r31, r32, r33 (low bits first), zero pad
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // qx, qy, qz, qw (low bits first), zero pad
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]     o_m_tdata,
    // invalid
    output logic [0:0]                            o_m_tuser
);

    localparam int DW   = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int LW   = DW + 1;
    localparam int MXW  = (F + 1 > DW) ? F + 1 : DW;
    localparam int SSW  = MXW + 3;
    localparam int SPW  = SSW - 1;
    localparam int RWR  = SPW + F;
    localparam int HW   = (RWR + 1) / 2;
    localparam int RW   = 2 * HW;
    localparam int RMW  = HW + 2;
    localparam int NWB  = (LW + F > HW) ? LW + F : HW;
    localparam int NW   = NWB + 1;
    localparam int ODW  = ((4*DW+7)/8)*8;

    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- input decode ----------------
    logic signed [DW-1:0]  m [0:8];
    logic signed [SSW-1:0] e11, e22, e33, tr, s_sel;
    logic signed [SSW-1:0] one_s;
    logic signed [LW-1:0]  d_sel [0:2];
    t_diag                 dg_sel;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i] = i_s_tdata[i*DW +: DW];
        end
        one_s = SSW'(1) << F;
        e11   = SSW'(m[0]);
        e22   = SSW'(m[4]);
        e33   = SSW'(m[8]);
        tr    = e11 + e22 + e33;
        if (tr > 0) begin
            dg_sel   = DIAG_W;
            s_sel    = tr + one_s;
            d_sel[0] = LW'(m[5]) - LW'(m[7]);
            d_sel[1] = LW'(m[6]) - LW'(m[2]);
            d_sel[2] = LW'(m[1]) - LW'(m[3]);
        end else if (e11 >= e22 && e11 >= e33) begin
            dg_sel   = DIAG_X;
            s_sel    = one_s + e11 - e22 - e33;
            d_sel[0] = LW'(m[1]) + LW'(m[3]);
            d_sel[1] = LW'(m[2]) + LW'(m[6]);
            d_sel[2] = LW'(m[5]) - LW'(m[7]);
        end else if (e22 <= e33) begin
            dg_sel   = DIAG_Z;
            s_sel    = one_s + e33 - e11 - e22;
            d_sel[0] = LW'(m[6]) + LW'(m[2]);
            d_sel[1] = LW'(m[7]) + LW'(m[5]);
            d_sel[2] = LW'(m[1]) - LW'(m[3]);
        end else begin
            dg_sel   = DIAG_Y;
            s_sel    = one_s + e22 - e11 - e33;
            d_sel[0] = LW'(m[3]) + LW'(m[1]);
            d_sel[1] = LW'(m[7]) + LW'(m[5]);
            d_sel[2] = LW'(m[6]) - LW'(m[2]);
        end
    end

    // ---------------- square root pipe ----------------
    logic                  r_sq_vld  [0:HW];
    logic                  r_sq_inv  [0:HW];
    t_diag                 r_sq_dg   [0:HW];
    logic signed [LW-1:0]  r_sq_d    [0:HW][0:2];
    logic [RW-1:0]         r_sq_rad  [0:HW];
    logic [RMW-1:0]        r_sq_rem  [0:HW];
    logic [HW-1:0]         r_sq_root [0:HW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_inv[0]  <= s_sel[SSW-1] || (s_sel == '0);
            r_sq_dg[0]   <= dg_sel;
            r_sq_d[0]    <= d_sel;
            r_sq_rad[0]  <= RW'({s_sel[SPW-1:0], {F{1'b0}}});
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < HW; k++) begin : g_sqrt
            logic [RMW-1:0] n_rem, sh, trial;
            logic [HW-1:0]  n_root;
            always_comb begin
                sh    = {r_sq_rem[k][RMW-3:0], r_sq_rad[k][RW-1 -: 2]};
                trial = {r_sq_root[k], 2'b01};
                if (sh >= trial) begin
                    n_rem  = sh - trial;
                    n_root = {r_sq_root[k][HW-2:0], 1'b1};
                end else begin
                    n_rem  = sh;
                    n_root = {r_sq_root[k][HW-2:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k+1] <= 1'b0;
                end else if (en) begin
                    r_sq_vld[k+1] <= r_sq_vld[k];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_inv[k+1]  <= r_sq_inv[k];
                    r_sq_dg[k+1]   <= r_sq_dg[k];
                    r_sq_d[k+1]    <= r_sq_d[k];
                    r_sq_rad[k+1]  <= {r_sq_rad[k][RW-3:0], 2'b00};
                    r_sq_rem[k+1]  <= n_rem;
                    r_sq_root[k+1] <= n_root;
                end
            end
        end
    endgenerate

    // ---------------- divider pipe ----------------
    logic                  r_dv_vld  [0:NW];
    logic                  r_dv_inv  [0:NW];
    t_diag                 r_dv_dg   [0:NW];
    logic [HW-1:0]         r_dv_dq   [0:NW];
    logic [HW:0]           r_dv_dvs  [0:NW];
    logic                  r_dv_neg  [0:NW][0:2];
    logic [NW-1:0]         r_dv_nq   [0:NW][0:2];
    logic [RMW-1:0]        r_dv_rem  [0:NW][0:2];

    logic [HW-1:0] h;
    logic [HW:0]   h_inc;
    logic [LW-1:0] mag [0:2];

    always_comb begin
        h     = r_sq_root[HW];
        h_inc = {1'b0, h} + 1'b1;
        for (int i = 0; i < NUM_LANES; i++) begin
            mag[i] = r_sq_d[HW][i][LW-1] ? LW'(-r_sq_d[HW][i]) : LW'(r_sq_d[HW][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_sq_vld[HW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_inv[0] <= r_sq_inv[HW];
            r_dv_dg[0]  <= r_sq_dg[HW];
            r_dv_dq[0]  <= h_inc[HW:1];
            r_dv_dvs[0] <= {h, 1'b0};
            for (int i = 0; i < NUM_LANES; i++) begin
                r_dv_neg[0][i] <= r_sq_d[HW][i][LW-1];
                r_dv_nq[0][i]  <= (NW'(mag[i]) << F) + NW'(h);
                r_dv_rem[0][i] <= '0;
            end
        end
    end

    genvar j, l;
    generate
        for (j = 0; j < NW; j++) begin : g_div
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[j+1] <= 1'b0;
                end else if (en) begin
                    r_dv_vld[j+1] <= r_dv_vld[j];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_inv[j+1] <= r_dv_inv[j];
                    r_dv_dg[j+1]  <= r_dv_dg[j];
                    r_dv_dq[j+1]  <= r_dv_dq[j];
                    r_dv_dvs[j+1] <= r_dv_dvs[j];
                    r_dv_neg[j+1] <= r_dv_neg[j];
                end
            end
            for (l = 0; l < NUM_LANES; l++) begin : g_lane
                logic [RMW-1:0] sh;
                logic           ge;
                always_comb begin
                    sh = {r_dv_rem[j][l][RMW-2:0], r_dv_nq[j][l][NW-1]};
                    ge = sh >= RMW'(r_dv_dvs[j]);
                end
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dv_rem[j+1][l] <= ge ? sh - RMW'(r_dv_dvs[j]) : sh;
                        r_dv_nq[j+1][l]  <= {r_dv_nq[j][l][NW-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    // ---------------- output register ----------------
    function automatic logic [DW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] lim;
        lim = NW'(1) << (DW - 1);
        if (neg) begin
            sat_q = (q > lim) ? {1'b1, {(DW-1){1'b0}}} : DW'(-q);
        end else begin
            sat_q = (q > lim - 1'b1) ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
        end
    endfunction

    logic [DW-1:0] comp [0:3];
    logic [ODW-1:0] n_tdata;

    always_comb begin
        logic [1:0]    ln;
        logic [HW-1:0] dmax;
        dmax    = HW'({(DW-1){1'b1}});
        n_tdata = '0;
        for (int c = 0; c < 4; c++) begin
            ln = (2'(c) < r_dv_dg[NW]) ? 2'(c) : 2'(c - 1);
            if (2'(c) == r_dv_dg[NW]) begin
                comp[c] = (HW > DW - 1 && r_dv_dq[NW] > dmax) ? DW'(dmax)
                                                              : DW'(r_dv_dq[NW]);
            end else begin
                comp[c] = sat_q(r_dv_nq[NW][ln], r_dv_neg[NW][ln]);
            end
            if (!r_dv_inv[NW]) begin
                n_tdata[c*DW +: DW] = comp[c];
            end
        end
    end

    logic           r_o_vld;
    logic [ODW-1:0] r_o_data;
    logic           r_o_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_dv_vld[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= n_tdata;
            r_o_inv  <= r_dv_inv[NW];
        end
    end

    assign o_m_tvalid   = r_o_vld;
    assign o_m_tdata    = r_o_data;
    assign o_m_tuser[0] = r_o_inv;

`ifndef SYNTHESIS
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("invalid result carries nonzero data");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[4*DW-1:0] != '0)
        else $error("valid quaternion is all zero");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld[HW] |-> r_sq_rem[HW] <= RMW'({r_sq_root[HW], 1'b0}))
        else $error("square root remainder out of range");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[NW] && !r_dv_inv[NW] |-> r_dv_rem[NW][0] < RMW'(r_dv_dvs[NW]))
        else $error("divider remainder out of range");
`endif

endmodule
